@@ rtl/core/stream_fixed_pattern_replace_assert.svh @@
// Assertion macros shared by the pattern replace RTL.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef STREAM_FIXED_PATTERN_REPLACE_ASSERT_SVH
`define STREAM_FIXED_PATTERN_REPLACE_ASSERT_SVH

`ifndef SYNTH
`define SFPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sfpr: assertion failed");
`define SFPR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sfpr: forbidden condition seen");
`else
`define SFPR_ASSERT(name, prop)
`define SFPR_ASSERT_NEVER(name, cond)
`endif

`endif

@@ rtl/core/sfpr_pkg.sv @@
// Shared types and constants for the fixed pattern replace block.
// Depends on nothing; used by every module of the block.
package sfpr_pkg;

  localparam int ByteW    = 8;
  localparam int PatLenW  = 4;
  localparam int PatW     = 64;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgPatternLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOldPattern = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNewPattern = 2'd2;

  // Per-cell control for the window row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // One result of the rewritten stream.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             flag;
  } out_item_t;

endpackage

@@ rtl/core/sfpr_cell.sv @@
// One byte cell of the sliding window row, with its pattern comparator.
// Depends on sfpr_pkg.
module sfpr_cell (
  input  logic                       clk_i,
  input  sfpr_pkg::cell_ctrl_t       ctrl_i,
  input  logic [sfpr_pkg::ByteW-1:0] new_byte_i,
  input  logic [sfpr_pkg::ByteW-1:0] next_byte_i,
  input  logic [sfpr_pkg::ByteW-1:0] pat_byte_i,
  output logic [sfpr_pkg::ByteW-1:0] byte_o,
  output logic                       match_o
);
  import sfpr_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  // A load beats a shift, so a pop and an append can share one cycle.
  always_comb begin
    if (ctrl_i.load) begin
      byte_d = new_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_d == pat_byte_i);

endmodule

@@ rtl/core/sfpr_out_buf.sv @@
// Two-entry result buffer that decouples the window from the receiver.
// Depends on sfpr_pkg.
module sfpr_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sfpr_pkg::out_item_t   item_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sfpr_pkg::out_item_t   item_o
);
  import sfpr_pkg::*;

  out_item_t  ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign item_o      = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/stream_fixed_pattern_replace.sv @@
// Fixed-length pattern substitution on a byte stream: sequencer, window row and
// result buffer. Depends on sfpr_pkg, sfpr_cell, sfpr_out_buf and the assert header.
//
// Usage: bytes arrive on the in_* channel, each with in_last marking the end of a
// stream. A window of pattern_len bytes slides over the stream; once full, each new
// byte pushes the oldest one out as a result. A full window equal to old_pattern is
// replaced by new_pattern and emptied, and the last byte flushes whatever remains.
// The final result of a stream has out_last set and replaced_flag telling whether
// any replacement took place. Registers are written on the cfg_* channel, which is
// always ready; the user must write them only while the block is idle, which the
// block itself does not enforce. Throughput: one byte per cycle in the steady state,
// while the receiver keeps up, since every step of the window row produces at most
// one result and the row is the only shared resource. A match holds the input while
// the replacement is emitted, and the last byte of a stream holds it while the rest
// is flushed. A byte pushed out of the window enters the result buffer with the
// transaction that caused it and is visible from the next cycle. A stalled receiver
// fills the two-entry result buffer, after which the input channel stops accepting.
// Reset empties the window and the buffer and restores pattern_len to one and both
// patterns to zero.
`include "stream_fixed_pattern_replace_assert.svh"

module stream_fixed_pattern_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sfpr_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         in_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfpr_pkg::ByteW-1:0]   out_byte_o,
  output logic                         out_last_o,
  output logic                         replaced_flag_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfpr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfpr_pkg::PatW-1:0]    cfg_data_i
);
  import sfpr_pkg::*;

  localparam int CntW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [3:0] {
    ST_RUN    = 4'b0001,
    ST_SHRINK = 4'b0010,
    ST_REPL   = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              repl_last_q, repl_last_d;
  logic              replaced_any_q, replaced_any_d;
  logic [PatLenW-1:0] pattern_len_q;
  logic [PatW-1:0]   old_pattern_q;
  logic [PatW-1:0]   new_pattern_q;
  logic [ByteW-1:0]  hold_byte_q;
  logic              hold_last_q;

  logic [CntW-1:0]   eff_len;
  logic [IdxW-1:0]   last_idx;
  logic              buf_space;
  logic              accept, over_full;
  logic              shrink_pop_run, step_run, shrink_busy, shrink_pop, step_hold;
  logic              flush_pop, repl_emit, step, step_pop, step_match, step_last;
  logic              pop, emit;
  logic [ByteW-1:0]  step_byte;
  logic [CntW-1:0]   new_fill, load_idx;
  logic [MAX_PATTERN-1:0] cell_match, len_mask;
  logic [ByteW-1:0]  cell_byte [MAX_PATTERN];
  cell_ctrl_t        cell_ctrl [MAX_PATTERN];
  out_item_t         emit_item, out_item;

  // Out-of-range lengths are clamped: zero acts as one.
  always_comb begin
    if (pattern_len_q == '0) begin
      eff_len = CntW'(1);
    end else if (int'(pattern_len_q) > MAX_PATTERN) begin
      eff_len = CntW'(MAX_PATTERN);
    end else begin
      eff_len = CntW'(pattern_len_q);
    end
  end
  assign last_idx = IdxW'(eff_len - CntW'(1));

  // Transaction scheduling. A window longer than the length (after it was shrunk) is
  // drained one byte a cycle while the buffer has space, before the held byte steps.
  assign in_ready_o     = (state_q == ST_RUN) && buf_space;
  assign accept         = in_valid_i && in_ready_o;
  assign over_full      = (fill_q > eff_len);
  assign shrink_pop_run = accept && over_full;
  assign step_run       = accept && !over_full;
  assign shrink_busy    = (state_q == ST_SHRINK) && buf_space;
  assign shrink_pop     = shrink_busy && over_full;
  assign step_hold      = shrink_busy && !over_full;
  assign flush_pop      = (state_q == ST_FLUSH) && buf_space;
  assign repl_emit      = (state_q == ST_REPL) && buf_space;

  assign step      = step_run || step_hold;
  assign step_byte = step_hold ? hold_byte_q : in_byte_i;
  assign step_last = step_hold ? hold_last_q : in_last_i;
  assign step_pop  = (fill_q == eff_len);
  assign new_fill  = step_pop ? fill_q : fill_q + CntW'(1);
  assign load_idx  = step_pop ? fill_q - CntW'(1) : fill_q;

  assign pop  = shrink_pop_run || shrink_pop || flush_pop || (step && step_pop);
  assign emit = pop || repl_emit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [ByteW-1:0] next_byte;
    if (k == MAX_PATTERN - 1) begin : g_tail
      assign next_byte = '0;
    end else begin : g_link
      assign next_byte = cell_byte[k+1];
    end

    assign cell_ctrl[k].shift = pop;
    assign cell_ctrl[k].load  = step && (load_idx == CntW'(k));
    assign len_mask[k]        = (CntW'(k) < eff_len);

    sfpr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[k]),
      .new_byte_i  (step_byte),
      .next_byte_i (next_byte),
      .pat_byte_i  (old_pattern_q[k*ByteW +: ByteW]),
      .byte_o      (cell_byte[k]),
      .match_o     (cell_match[k])
    );
  end

  assign step_match = (new_fill == eff_len) && (&(cell_match | ~len_mask));

  always_comb begin
    emit_item.data = repl_emit ? new_pattern_q[cnt_q*ByteW +: ByteW] : cell_byte[0];
    emit_item.last = (flush_pop && (fill_q == CntW'(1))) ||
                     (repl_emit && (cnt_q == last_idx) && repl_last_q);
    emit_item.flag = emit_item.last && replaced_any_q;
  end

  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    cnt_d          = cnt_q;
    repl_last_d    = repl_last_q;
    replaced_any_d = replaced_any_q;
    unique case (state_q)
      ST_RUN: begin
        if (shrink_pop_run) begin
          fill_d  = fill_q - CntW'(1);
          state_d = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        if (shrink_pop) begin
          fill_d = fill_q - CntW'(1);
        end
      end
      ST_REPL: begin
        if (repl_emit) begin
          if (cnt_q == last_idx) begin
            cnt_d   = '0;
            state_d = ST_RUN;
            if (repl_last_q) begin
              replaced_any_d = 1'b0;
            end
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (flush_pop) begin
          fill_d = fill_q - CntW'(1);
          if (fill_q == CntW'(1)) begin
            replaced_any_d = 1'b0;
            state_d        = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    if (step) begin
      if (step_match) begin
        replaced_any_d = 1'b1;
        fill_d         = '0;
        cnt_d          = '0;
        repl_last_d    = step_last;
        state_d        = ST_REPL;
      end else begin
        fill_d  = new_fill;
        state_d = step_last ? ST_FLUSH : ST_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_RUN;
      fill_q         <= '0;
      cnt_q          <= '0;
      repl_last_q    <= 1'b0;
      replaced_any_q <= 1'b0;
      pattern_len_q  <= PatLenW'(1);
      old_pattern_q  <= '0;
      new_pattern_q  <= '0;
    end else begin
      state_q        <= state_d;
      fill_q         <= fill_d;
      cnt_q          <= cnt_d;
      repl_last_q    <= repl_last_d;
      replaced_any_q <= replaced_any_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPatternLen: pattern_len_q <= cfg_data_i[PatLenW-1:0];
          CfgOldPattern: old_pattern_q <= cfg_data_i;
          CfgNewPattern: new_pattern_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shrink_pop_run) begin
      hold_byte_q <= in_byte_i;
      hold_last_q <= in_last_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  sfpr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .item_i      (emit_item),
    .space_o     (buf_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (out_item)
  );

  assign out_byte_o      = out_item.data;
  assign out_last_o      = out_item.last;
  assign replaced_flag_o = out_item.flag;

  `SFPR_ASSERT_NEVER(fill_bound_a, fill_q > CntW'(MAX_PATTERN))
  `SFPR_ASSERT_NEVER(flush_nonempty_a, (state_q == ST_FLUSH) && (fill_q == '0))
  `SFPR_ASSERT_NEVER(repl_empty_window_a, (state_q == ST_REPL) && (fill_q != '0))
  `SFPR_ASSERT_NEVER(push_when_full_a, emit && !buf_space)
  `SFPR_ASSERT(final_clears_flag_a, (emit && emit_item.last) |=> !replaced_any_q)

endmodule

@@ test/stream_fixed_pattern_replace_tb.sv @@
// Self-checking testbench for stream_fixed_pattern_replace.
// Depends on sfpr_pkg and the block's RTL; a scoreboard class predicts the rewritten
// stream, directed cases come first and random pattern-rich streams follow.
module stream_fixed_pattern_replace_tb;

  localparam logic [sfpr_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int MaxPattern = 8;
  localparam int QuietLimit = 1000;

  typedef struct packed {
    logic [sfpr_pkg::ByteW-1:0] b;
    logic                       last;
  } stream_beat_t;

  // Predicts the rewritten stream and holds the bytes still owed by the block.
  class pattern_scoreboard;
    logic [sfpr_pkg::PatLenW-1:0] pat_len;
    logic [sfpr_pkg::PatW-1:0]    old_pat;
    logic [sfpr_pkg::PatW-1:0]    new_pat;
    logic [sfpr_pkg::ByteW-1:0]   window [MaxPattern];
    int unsigned                  fill;
    bit                           replaced_any;
    sfpr_pkg::out_item_t          owed_q[$];
    int unsigned errors, bytes_in, bytes_out, replacements, streams;

    function new();
      pat_len      = 4'd1;
      old_pat      = '0;
      new_pat      = '0;
      fill         = 0;
      replaced_any = 1'b0;
      errors       = 0;
      bytes_in     = 0;
      bytes_out    = 0;
      replacements = 0;
      streams      = 0;
    endfunction

    function void write_reg(logic [sfpr_pkg::CfgIdxW-1:0] idx, logic [sfpr_pkg::PatW-1:0] data);
      case (idx)
        sfpr_pkg::CfgPatternLen: pat_len = data[sfpr_pkg::PatLenW-1:0];
        sfpr_pkg::CfgOldPattern: old_pat = data;
        sfpr_pkg::CfgNewPattern: new_pat = data;
        default: ;
      endcase
    endfunction

    // Length in force: zero behaves as one, anything above the maximum as the maximum.
    function int unsigned span();
      if (pat_len == 0) return 1;
      if (pat_len > MaxPattern) return MaxPattern;
      return pat_len;
    endfunction

    function void note_input(logic [sfpr_pkg::ByteW-1:0] b, logic last);
      sfpr_pkg::out_item_t step_out [MaxPattern+1];
      int unsigned len;
      int unsigned n;
      bit hit;
      len = span();
      n   = 0;
      bytes_in++;
      // A full window, or one left over-full by a shortened length, drains down to one below the length.
      while (fill >= len && fill > 0) begin
        step_out[n] = {window[0], 2'b00};
        n++;
        for (int i = 1; i < fill; i++) window[i-1] = window[i];
        fill--;
      end
      if (fill < MaxPattern) begin
        window[fill] = b;
        fill++;
      end
      if (fill == len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (window[i] != old_pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < len; i++) begin
            step_out[n] = {new_pat[8*i +: 8], 2'b00};
            n++;
          end
          fill = 0;
          replaced_any = 1'b1;
          replacements++;
        end
      end
      if (last) begin
        for (int i = 0; i < fill; i++) begin
          step_out[n] = {window[i], 2'b00};
          n++;
        end
        fill = 0;
        if (n > 0) begin
          step_out[n-1].last = 1'b1;
          step_out[n-1].flag = replaced_any;
        end
        replaced_any = 1'b0;
        streams++;
      end
      for (int i = 0; i < n; i++) owed_q.push_back(step_out[i]);
    endfunction

    function void check_result(logic [sfpr_pkg::ByteW-1:0] b, logic last, logic flag);
      sfpr_pkg::out_item_t want;
      bytes_out++;
      if (owed_q.size() == 0) begin
        $error("out_byte %02h arrived with nothing outstanding", b);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.data !== b) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, b);
        errors++;
      end
      if (want.last !== last) begin
        $error("out_last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (want.flag !== flag) begin
        $error("replaced_flag mismatch: expected %0b, actual %0b", want.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [sfpr_pkg::ByteW-1:0]   in_byte = '0;
  logic                         in_last = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [sfpr_pkg::ByteW-1:0]   out_byte;
  logic                         out_last;
  logic                         replaced_flag;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sfpr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sfpr_pkg::PatW-1:0]    cfg_data = '0;

  pattern_scoreboard sb;
  stream_beat_t      beats[$];
  int unsigned       stream_left = 5;
  bit                calm = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       quiet = 0;

  stream_fixed_pattern_replace #(
    .MAX_PATTERN(MaxPattern)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .in_last_i      (in_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .out_last_o     (out_last),
    .replaced_flag_o(replaced_flag),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk = ~clk;

  // Every completed transaction is handed to the scoreboard at the edge it happens.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(in_byte, in_last);
      if (out_valid && out_ready) sb.check_result(out_byte, out_last, replaced_flag);
    end
  end

  // Receiver with random stall bursts, none started while calm is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QuietLimit) begin
        $display("Watchdog: no transaction for %0d cycles", QuietLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void push_beat(logic [sfpr_pkg::ByteW-1:0] b, logic last);
    beats.push_back({b, last});
  endfunction

  // Random streams end wherever their drawn length runs out, phase boundaries included.
  function automatic void push_byte(logic [sfpr_pkg::ByteW-1:0] b);
    stream_left--;
    push_beat(b, stream_left == 0);
    if (stream_left == 0) stream_left = $urandom_range(1, 24);
  endfunction

  task automatic write_cfg(logic [sfpr_pkg::CfgIdxW-1:0] idx, logic [sfpr_pkg::PatW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beats();
    stream_beat_t bt;
    while (beats.size() > 0) begin
      bt = beats.pop_front();
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= bt.b;
      in_last  <= bt.last;
      do @(posedge clk); while (!in_ready);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits for every owed byte, then gives a byte that produced nothing time to land.
  task automatic settle();
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_phase(int forced_len, int count);
    logic [sfpr_pkg::PatW-1:0] data;
    logic [sfpr_pkg::PatW-1:0] old_p;
    int unsigned len_raw;
    int unsigned len;
    int unsigned pick;
    if (forced_len >= 0) len_raw = forced_len;
    else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len_raw = 0;
      else if (pick == 1) len_raw = $urandom_range(9, 15);
      else len_raw = $urandom_range(1, 8);
    end
    data = {$urandom, $urandom};
    data[sfpr_pkg::PatLenW-1:0] = len_raw[sfpr_pkg::PatLenW-1:0];
    write_cfg(sfpr_pkg::CfgPatternLen, data);
    // Now and then only the length moves, so an open stream sees it change under it.
    if (forced_len >= 0 || $urandom_range(0, 2) != 0) begin
      old_p = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0)
        for (int k = 0; k < MaxPattern; k++)
          old_p[8*k +: 8] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
      write_cfg(sfpr_pkg::CfgOldPattern, old_p);
      write_cfg(sfpr_pkg::CfgNewPattern, {$urandom, $urandom});
    end
    if ($urandom_range(0, 3) == 0) write_cfg(CfgSpare, {$urandom, $urandom});
    len = sb.span();
    while (beats.size() < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        for (int k = 0; k < len; k++) push_byte(sb.old_pat[8*k +: 8]);
      end else if (pick < 7) begin
        repeat (1) begin
          int unsigned part;
          part = $urandom_range(1, len);
          for (int k = 0; k < part; k++) push_byte(sb.old_pat[8*k +: 8]);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 1) push_byte(sb.old_pat[8*$urandom_range(0, len-1) +: 8]);
          else push_byte($urandom_range(0, 255));
        end
      end
    end
    send_beats();
    settle();
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: single-byte zero pattern replaced by zero.
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b1);
    send_beats();
    settle();

    // Three-byte pattern; the upper pattern bytes must play no part.
    write_cfg(sfpr_pkg::CfgPatternLen, 64'hFFFF_FFFF_FFFF_FFF3);
    write_cfg(sfpr_pkg::CfgOldPattern, 64'hFFFF_FFFF_FF43_4241);
    write_cfg(sfpr_pkg::CfgNewPattern, 64'hA5A5_A5A5_A57A_7978);
    push_beat(8'h41, 1'b0);
    push_beat(8'h42, 1'b0);
    push_beat(8'h43, 1'b0);
    push_beat(8'h59, 1'b0);
    push_beat(8'h41, 1'b0);
    push_beat(8'h42, 1'b0);
    push_beat(8'h43, 1'b1);
    push_beat(8'h41, 1'b0);
    push_beat(8'h42, 1'b1);
    send_beats();
    settle();

    // Full-width window left open, then the length collapses to zero, which acts as one:
    // the next byte drains all eight held bytes and is itself replaced.
    write_cfg(CfgSpare, '1);
    write_cfg(sfpr_pkg::CfgPatternLen, 64'd8);
    write_cfg(sfpr_pkg::CfgOldPattern, '1);
    write_cfg(sfpr_pkg::CfgNewPattern, '1);
    repeat (7) push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    send_beats();
    settle();
    write_cfg(sfpr_pkg::CfgPatternLen, 64'hF0);
    write_cfg(sfpr_pkg::CfgOldPattern, 64'hAA);
    push_beat(8'hAA, 1'b1);
    send_beats();
    settle();

    stream_left = $urandom_range(1, 24);
    for (int p = 0; p < 7; p++) begin
      calm = (p == 6);
      random_phase(p == 1 ? 15 : (p == 2 ? 8 : -1), 25);
    end
    repeat (10) @(negedge clk);

    $display("Checked %0d output bytes against %0d input bytes in %0d streams.",
             sb.bytes_out, sb.bytes_in, sb.streams);
    $display("Lengths from zero to fifteen were programmed; %0d replacements were predicted.",
             sb.replacements);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.owed_q.size() != 0) $error("%0d output bytes never arrived", sb.owed_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
